// ----- src/bulge_arc_tessellator_defines.svh -----
// Assertion macros shared by the bulge arc tessellator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BULGE_ARC_TESSELLATOR_DEFINES_SVH
`define BULGE_ARC_TESSELLATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bat_pkg.sv -----
// Package for the bulge arc tessellator: word types, segment descriptor,
// sequencer states, CORDIC table and shared constants. No dependencies.
package bat_pkg;

    localparam int DEF_STEPS_PER_HALF_TURN = 18;
    localparam int DEF_COORD_FRAC_BITS     = 16;

    // datapath widths
    localparam int CW = 64;   // CORDIC vector and product width
    localparam int AW = 34;   // angle accumulator width
    localparam int IW = 5;    // CORDIC iteration index

    localparam int CORDIC_ITERS = 24;
    localparam int GUARD_BITS   = 24;
    localparam int MUL_SH_M     = 30;
    localparam int MUL_SH_P     = 32 + GUARD_BITS;

    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [AW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic signed [AW-1:0] HALF_TURN    = 34'sh0_8000_0000;
    localparam logic signed [AW-1:0] ATAN_MAX     = 34'sh0_3FFF_FFFF;
    localparam logic [CW-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // atan(2^-i) as binary angle, full turn = 2^32
    function automatic logic [31:0] atan_entry(input logic [IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680350;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // clamp a 65-bit sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -65'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] bulge;
        logic               emit_end;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               last_point;
    } t_out_word;

    // classified segment handed from front to back
    typedef struct packed {
        logic signed [31:0]   sx;
        logic signed [31:0]   sy;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   bulge;
        logic [31:0]          absb;
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic                 emit_end;
        logic                 arc;
    } t_seg;

    typedef struct packed {
        logic start;
        logic vector;
    } t_cordic_ctl;

    typedef struct packed {
        logic start;
        logic long_sh;
    } t_mul_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ATAN,
        S_STEPS,
        S_EMIT_START,
        S_DIVQ,
        S_DIVH,
        S_NEXT,
        S_ROT,
        S_RWAIT,
        S_MUL_M,
        S_MUL_X,
        S_MUL_Y,
        S_EMIT_PT,
        S_EMIT_END
    } t_state;

endpackage

// ----- src/bat_front.sv -----
// Front end: accepts segment words, classifies them and scales the chord;
// holds classified segments in a two-entry queue. Depends on bat_pkg.
module bat_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bat_pkg::t_in_word i_in_word,
    input  logic              i_pop,
    output logic              o_seg_valid,
    output bat_pkg::t_seg     o_seg
);

    bat_pkg::t_seg       r_mem [2];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    bat_pkg::t_seg       w_seg;
    logic signed [32:0]  w_dx, w_dy;
    logic signed [64:0]  w_px, w_py;
    logic                w_push;

    // chord, gain-compensated chord and arc classification
    always_comb begin
        w_dx = $signed({i_in_word.end_x[31], i_in_word.end_x})
             - $signed({i_in_word.start_x[31], i_in_word.start_x});
        w_dy = $signed({i_in_word.end_y[31], i_in_word.end_y})
             - $signed({i_in_word.start_y[31], i_in_word.start_y});
        w_px = w_dx * bat_pkg::INV_GAIN_Q30;
        w_py = w_dy * bat_pkg::INV_GAIN_Q30;
        w_seg.sx       = i_in_word.start_x;
        w_seg.sy       = i_in_word.start_y;
        w_seg.ex       = i_in_word.end_x;
        w_seg.ey       = i_in_word.end_y;
        w_seg.bulge    = i_in_word.bulge;
        w_seg.absb     = i_in_word.bulge[31] ? (32'd0 - i_in_word.bulge) : i_in_word.bulge;
        // floor shift of the signed product
        w_seg.x0       = $signed(w_px[63:0]) >>> (30 - bat_pkg::GUARD_BITS);
        w_seg.y0       = $signed(w_py[63:0]) >>> (30 - bat_pkg::GUARD_BITS);
        w_seg.emit_end = i_in_word.emit_end;
        w_seg.arc      = (i_in_word.bulge != 32'sd0) && ((w_dx != 33'sd0) || (w_dy != 33'sd0));
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_seg_valid = (r_cnt != 2'd0);
    assign o_seg       = r_mem[r_rp];
    assign w_push      = i_in_valid && o_in_ready;

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_seg;
        end
    end

endmodule

// ----- src/bat_cordic.sv -----
// Iterative CORDIC: one iteration per cycle, rotation or vectoring mode.
// Results hold until the next start. Depends on bat_pkg.
module bat_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bat_pkg::t_cordic_ctl               i_ctl,
    input  logic signed [bat_pkg::CW-1:0]      i_x,
    input  logic signed [bat_pkg::CW-1:0]      i_y,
    input  logic [31:0]                        i_ang,
    output logic                               o_busy,
    output logic signed [bat_pkg::CW-1:0]      o_x,
    output logic signed [bat_pkg::CW-1:0]      o_y,
    output logic signed [bat_pkg::AW-1:0]      o_z
);

    logic signed [bat_pkg::CW-1:0] r_x, r_y, n_x, n_y, w_tx, w_ty;
    logic signed [bat_pkg::AW-1:0] r_z, n_z, w_ang, w_at;
    logic [bat_pkg::IW-1:0]        r_i, n_i;
    logic                          r_busy, n_busy, r_vec, n_vec, w_cw;

    always_comb begin
        w_ang  = $signed({{(bat_pkg::AW-32){i_ang[31]}}, i_ang});
        w_at   = $signed({{(bat_pkg::AW-32){1'b0}}, bat_pkg::atan_entry(r_i)});
        w_tx   = r_y >>> r_i;
        w_ty   = r_x >>> r_i;
        // counter-clockwise micro-rotation: vectoring on negative y, rotating on z >= 0
        w_cw   = r_vec ? r_y[bat_pkg::CW-1] : ~r_z[bat_pkg::AW-1];
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_i    = r_i;
        n_busy = r_busy;
        n_vec  = r_vec;
        if (i_ctl.start) begin
            // load, folding the angle into one quarter turn either side
            n_busy = 1'b1;
            n_vec  = i_ctl.vector;
            n_i    = '0;
            n_x    = i_x;
            n_y    = i_y;
            n_z    = '0;
            if (!i_ctl.vector) begin
                n_z = w_ang;
                if (w_ang > bat_pkg::QUARTER_TURN) begin
                    n_x = -i_x;
                    n_y = -i_y;
                    n_z = w_ang - bat_pkg::HALF_TURN;
                end else if (w_ang < -bat_pkg::QUARTER_TURN) begin
                    n_x = -i_x;
                    n_y = -i_y;
                    n_z = w_ang + bat_pkg::HALF_TURN;
                end
            end
        end else if (r_busy) begin
            if (w_cw) begin
                n_x = r_x - w_tx;
                n_y = r_y + w_ty;
                n_z = r_z - w_at;
            end else begin
                n_x = r_x + w_tx;
                n_y = r_y - w_ty;
                n_z = r_z + w_at;
            end
            n_i    = r_i + 1'b1;
            n_busy = (r_i != bat_pkg::IW'(bat_pkg::CORDIC_ITERS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_i   <= n_i;
        r_vec <= n_vec;
    end

    assign o_busy = r_busy;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ----- src/bat_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Results hold until the next start. No dependencies.
module bat_div #(
    parameter int DW = 49
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [31:0]   i_den,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [31:0]   o_rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_q;
    logic [31:0]     r_r, r_d;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic [32:0]     w_t, w_diff;
    logic            w_ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_t    = {r_r, r_q[DW-1]};
        w_ge   = (w_t >= {1'b0, r_d});
        w_diff = w_t - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == CNTW'(1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_r   <= '0;
            r_d   <= i_den;
            r_cnt <= CNTW'(DW);
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_ge};
            r_r   <= w_ge ? w_diff[31:0] : w_t[31:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ----- src/bat_mul.sv -----
// Sign-magnitude 64x64 multiply with a selectable right shift (30 or 56 bits)
// and saturation, built from four 32x32 partial products. Depends on bat_pkg.
module bat_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bat_pkg::t_mul_ctl             i_ctl,
    input  logic signed [bat_pkg::CW-1:0] i_a,
    input  logic signed [bat_pkg::CW-1:0] i_b,
    output logic                          o_busy,
    output logic signed [bat_pkg::CW-1:0] o_p
);

    logic [63:0]  r_ua, r_ub, w_sh, w_mag;
    logic [127:0] r_acc, w_ppx;
    logic [31:0]  w_ah, w_bh;
    logic [63:0]  w_pp;
    logic [2:0]   r_j;
    logic         r_neg, r_long, r_busy, w_ovf;
    logic signed [bat_pkg::CW-1:0] r_p;

    // partial product for the current half pair
    always_comb begin
        w_ah = r_j[1] ? r_ua[63:32] : r_ua[31:0];
        w_bh = r_j[0] ? r_ub[63:32] : r_ub[31:0];
        w_pp = w_ah * w_bh;
        case ({1'b0, r_j[1]} + {1'b0, r_j[0]})
            2'd0:    w_ppx = {64'd0, w_pp};
            2'd1:    w_ppx = {32'd0, w_pp, 32'd0};
            default: w_ppx = {w_pp, 64'd0};
        endcase
    end

    // shift, saturate to the positive int64 range
    always_comb begin
        if (r_long) begin
            w_sh  = r_acc[bat_pkg::MUL_SH_P +: 64];
            w_ovf = |r_acc[127:bat_pkg::MUL_SH_P+63];
        end else begin
            w_sh  = r_acc[bat_pkg::MUL_SH_M +: 64];
            w_ovf = |r_acc[127:bat_pkg::MUL_SH_M+63];
        end
        w_mag = w_ovf ? bat_pkg::INT64_MAX : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_j == 3'd4)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_ua   <= i_a[63] ? (64'd0 - i_a) : i_a;
            r_ub   <= i_b[63] ? (64'd0 - i_b) : i_b;
            r_neg  <= i_a[63] ^ i_b[63];
            r_long <= i_ctl.long_sh;
            r_acc  <= '0;
            r_j    <= 3'd0;
        end else if (r_busy) begin
            if (r_j != 3'd4) begin
                r_acc <= r_acc + w_ppx;
                r_j   <= r_j + 3'd1;
            end else begin
                r_p <= r_neg ? $signed(64'd0 - w_mag) : $signed(w_mag);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_p    = r_p;

endmodule

// ----- src/bat_back.sv -----
// Back end: sequencer that computes the arc and emits points through an
// output register. Uses bat_cordic, bat_div, bat_mul and bat_pkg.
module bat_back #(
    parameter int STEPS_PER_HALF_TURN = bat_pkg::DEF_STEPS_PER_HALF_TURN,
    parameter int COORD_FRAC_BITS     = bat_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_seg_valid,
    input  bat_pkg::t_seg      i_seg,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bat_pkg::t_out_word o_out_word
);

    localparam int SW = $clog2(2 * STEPS_PER_HALF_TURN + 1);
    localparam int DW = COORD_FRAC_BITS + 33;
    localparam int AW = bat_pkg::AW;
    localparam int CW = bat_pkg::CW;

    bat_pkg::t_state    r_state, n_state;
    bat_pkg::t_seg      r_seg, n_seg;
    logic signed [AW-1:0] r_z, n_z, r_half, n_half;
    logic [32:0]        r_absw, n_absw;
    logic [SW-1:0]      r_steps, n_steps, r_k, n_k;
    logic [63:0]        r_q, n_q;
    logic [31:0]        r_qa, n_qa, r_h, n_h;
    logic [SW:0]        r_ra, n_ra, r_rem, n_rem;
    logic signed [CW-1:0] r_m, n_m, r_px, n_px;
    logic               r_ov, n_ov;
    bat_pkg::t_out_word r_ow, n_ow;

    bat_pkg::t_cordic_ctl a_ctl, b_ctl;
    bat_pkg::t_mul_ctl    m_ctl;
    logic                 a_busy, b_busy, d_busy, m_busy, d_start;
    logic signed [CW-1:0] a_x, a_y, b_x, b_y, a_in_x, a_in_y, m_a, m_b, m_p;
    logic signed [AW-1:0] a_z, b_z, w_zc, w_absz, w_hs, w_hsg, w_ang;
    logic [31:0]          a_ang, d_den, d_rem;
    logic [DW-1:0]        d_num, d_quot;
    logic [39:0]          w_prod, w_sum;
    logic [8:0]           w_sfull;
    logic [SW:0]          w_d;
    logic [SW+1:0]        w_remsum, w_remdiff;
    logic                 w_wrap, w_free, w_bpos, w_lastk;
    logic [63:0]          w_qsum;

    bat_cordic u_cordic_a (
        .i_clk, .i_rst_n, .i_ctl(a_ctl), .i_x(a_in_x), .i_y(a_in_y), .i_ang(a_ang),
        .o_busy(a_busy), .o_x(a_x), .o_y(a_y), .o_z(a_z)
    );

    bat_cordic u_cordic_b (
        .i_clk, .i_rst_n, .i_ctl(b_ctl), .i_x(r_seg.x0), .i_y(r_seg.y0),
        .i_ang(w_ang[31:0]), .o_busy(b_busy), .o_x(b_x), .o_y(b_y), .o_z(b_z)
    );

    bat_div #(.DW(DW)) u_div (
        .i_clk, .i_rst_n, .i_start(d_start), .i_num(d_num), .i_den(d_den),
        .o_busy(d_busy), .o_quot(d_quot), .o_rem(d_rem)
    );

    bat_mul u_mul (
        .i_clk, .i_rst_n, .i_ctl(m_ctl), .i_a(m_a), .i_b(m_b), .o_busy(m_busy), .o_p(m_p)
    );

    // arithmetic shared by several states
    always_comb begin
        // clamped atan from the vectoring pass
        if (a_z > bat_pkg::ATAN_MAX) begin
            w_zc = bat_pkg::ATAN_MAX;
        end else if (a_z < -bat_pkg::ATAN_MAX) begin
            w_zc = -bat_pkg::ATAN_MAX;
        end else begin
            w_zc = a_z;
        end
        // step count: ceil(|sweep| * S / half turn), at least one
        w_absz  = r_z[AW-1] ? -r_z : r_z;
        w_prod  = 40'({w_absz[30:0], 2'b00}) * 40'(STEPS_PER_HALF_TURN);
        w_sum   = w_prod + 40'h00_7FFF_FFFF;
        w_sfull = w_sum[39:31];
        // incremental floor(|sweep| * k / (2 * steps))
        w_d       = {r_steps, 1'b0};
        w_remsum  = {1'b0, r_rem} + {1'b0, r_ra};
        w_remdiff = w_remsum - {1'b0, w_d};
        w_wrap    = (w_remsum >= {1'b0, w_d});
        // chord rotation angle: sign(b)*h - half sweep
        w_bpos = !r_seg.bulge[31] && (r_seg.bulge != 32'sd0);
        w_hs   = $signed({{(AW-32){1'b0}}, r_h});
        w_hsg  = w_bpos ? w_hs : -w_hs;
        w_ang  = w_hsg - r_half;
        w_qsum = 64'(d_quot) + (64'(r_seg.absb) << (32 - COORD_FRAC_BITS));
        w_free = !r_ov || i_out_ready;
        w_lastk = (r_k == (r_steps - 1'b1));
    end

    // sequencer: next state, unit starts and register updates
    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_z     = r_z;
        n_half  = r_half;
        n_absw  = r_absw;
        n_steps = r_steps;
        n_k     = r_k;
        n_q     = r_q;
        n_qa    = r_qa;
        n_h     = r_h;
        n_ra    = r_ra;
        n_rem   = r_rem;
        n_m     = r_m;
        n_px    = r_px;
        n_ow    = r_ow;
        n_ov    = r_ov && !i_out_ready;
        o_pop   = 1'b0;
        a_ctl   = '0;
        b_ctl   = '0;
        m_ctl   = '0;
        d_start = 1'b0;
        a_in_x  = $signed(CW'(1) << (COORD_FRAC_BITS + 24));
        a_in_y  = $signed({{(CW-56){r_seg.bulge[31]}}, r_seg.bulge, 24'd0});
        a_ang   = r_h;
        d_num   = DW'(1) << (COORD_FRAC_BITS + 32);
        d_den   = r_seg.absb;
        m_a     = a_y;
        m_b     = $signed(r_q);
        unique case (r_state)
            bat_pkg::S_IDLE: begin
                if (i_seg_valid) begin
                    o_pop   = 1'b1;
                    n_seg   = i_seg;
                    n_steps = SW'(1);
                    n_state = i_seg.arc ? bat_pkg::S_ATAN : bat_pkg::S_EMIT_START;
                    // atan(b) by vectoring, launched on the pop
                    if (i_seg.arc) begin
                        a_ctl.start  = 1'b1;
                        a_ctl.vector = 1'b1;
                        a_in_y       = $signed({{(CW-56){i_seg.bulge[31]}}, i_seg.bulge,
                                                24'd0});
                    end
                end
            end
            bat_pkg::S_ATAN: begin
                // take the clamped angle once unit A goes idle
                if (!a_busy) begin
                    n_z     = w_zc;
                    n_half  = w_zc <<< 1;
                    n_state = bat_pkg::S_STEPS;
                end
            end
            bat_pkg::S_STEPS: begin
                n_absw  = {w_absz[30:0], 2'b00};
                n_steps = (w_sfull == 9'd0) ? SW'(1) : w_sfull[SW-1:0];
                d_start = 1'b1;
                n_state = bat_pkg::S_EMIT_START;
            end
            bat_pkg::S_EMIT_START: begin
                if (w_free) begin
                    n_ov                  = 1'b1;
                    n_ow.point_x          = r_seg.sx;
                    n_ow.point_y          = r_seg.sy;
                    n_ow.last_point       = (!r_seg.arc || (r_steps == SW'(1)))
                                            && !r_seg.emit_end;
                    if (r_seg.arc && (r_steps != SW'(1))) begin
                        n_state = bat_pkg::S_DIVQ;
                    end else if (r_seg.emit_end) begin
                        n_state = bat_pkg::S_EMIT_END;
                    end else begin
                        n_state = bat_pkg::S_IDLE;
                    end
                end
            end
            bat_pkg::S_DIVQ: begin
                d_num = DW'(r_absw);
                d_den = 32'(w_d);
                if (!d_busy) begin
                    n_q     = w_qsum >> 1;
                    d_start = 1'b1;
                    n_state = bat_pkg::S_DIVH;
                end
            end
            bat_pkg::S_DIVH: begin
                if (!d_busy) begin
                    n_qa    = d_quot[31:0];
                    n_ra    = d_rem[SW:0];
                    n_h     = '0;
                    n_rem   = '0;
                    n_k     = '0;
                    n_state = bat_pkg::S_NEXT;
                end
            end
            bat_pkg::S_NEXT: begin
                n_k     = r_k + 1'b1;
                n_h     = r_h + r_qa + {31'd0, w_wrap};
                n_rem   = w_wrap ? w_remdiff[SW:0] : w_remsum[SW:0];
                n_state = bat_pkg::S_ROT;
            end
            bat_pkg::S_ROT: begin
                // sine of h on unit A, chord rotation on unit B
                a_ctl.start = 1'b1;
                a_in_x      = $signed({{(CW-32){1'b0}}, bat_pkg::INV_GAIN_Q30});
                a_in_y      = '0;
                b_ctl.start = 1'b1;
                n_state     = bat_pkg::S_RWAIT;
            end
            bat_pkg::S_RWAIT: begin
                if (!a_busy && !b_busy) begin
                    m_ctl.start = 1'b1;
                    n_state     = bat_pkg::S_MUL_M;
                end
            end
            bat_pkg::S_MUL_M: begin
                m_a = b_x;
                m_b = m_p;
                if (!m_busy) begin
                    n_m           = m_p;
                    m_ctl.start   = 1'b1;
                    m_ctl.long_sh = 1'b1;
                    n_state       = bat_pkg::S_MUL_X;
                end
            end
            bat_pkg::S_MUL_X: begin
                m_a = b_y;
                m_b = r_m;
                if (!m_busy) begin
                    n_px          = m_p;
                    m_ctl.start   = 1'b1;
                    m_ctl.long_sh = 1'b1;
                    n_state       = bat_pkg::S_MUL_Y;
                end
            end
            bat_pkg::S_MUL_Y: begin
                if (!m_busy) begin
                    n_state = bat_pkg::S_EMIT_PT;
                end
            end
            bat_pkg::S_EMIT_PT: begin
                if (w_free) begin
                    n_ov            = 1'b1;
                    n_ow.point_x    = bat_pkg::sat32($signed({{33{r_seg.sx[31]}}, r_seg.sx})
                                      + $signed({r_px[CW-1], r_px}));
                    n_ow.point_y    = bat_pkg::sat32($signed({{33{r_seg.sy[31]}}, r_seg.sy})
                                      + $signed({m_p[CW-1], m_p}));
                    n_ow.last_point = w_lastk && !r_seg.emit_end;
                    if (!w_lastk) begin
                        n_state = bat_pkg::S_NEXT;
                    end else if (r_seg.emit_end) begin
                        n_state = bat_pkg::S_EMIT_END;
                    end else begin
                        n_state = bat_pkg::S_IDLE;
                    end
                end
            end
            bat_pkg::S_EMIT_END: begin
                if (w_free) begin
                    n_ov            = 1'b1;
                    n_ow.point_x    = r_seg.ex;
                    n_ow.point_y    = r_seg.ey;
                    n_ow.last_point = 1'b1;
                    n_state         = bat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bat_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg   <= n_seg;
        r_z     <= n_z;
        r_half  <= n_half;
        r_absw  <= n_absw;
        r_steps <= n_steps;
        r_k     <= n_k;
        r_q     <= n_q;
        r_qa    <= n_qa;
        r_h     <= n_h;
        r_ra    <= n_ra;
        r_rem   <= n_rem;
        r_m     <= n_m;
        r_px    <= n_px;
        r_ow    <= n_ow;
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

endmodule

// ----- src/bulge_arc_tessellator.sv -----
// Bulge arc tessellator top level: front classifier, segment queue and
// arc sequencer. Uses bat_pkg, bat_front, bat_back and the assertion header.
//
// Usage:
//   Input channel i_in_valid / o_in_ready / i_in_word carries one polyline
//   segment per word (start, end, bulge, emit_end). Output channel
//   o_out_valid / i_out_ready / o_out_word carries the points it causes; the
//   final point of a segment has last_point set.
//   A segment is classified on entry and queued (two entries), so the input
//   is taken while earlier segments are still being worked on.
//   Sequence: a straight or zero-chord segment goes directly to its start
//   point once it reaches the sequencer. An arc first runs a vectoring
//   CORDIC pass before its start point, then two serial divisions, then
//   for each interior point a CORDIC pair (units A and B together) and
//   three multiplies on the shared serial multiplier.
//   Reset clears the queue and the sequencer; no point is pending after it.
//   A stalled receiver holds the output register, and the sequencer and
//   then the queue stop behind it; nothing is dropped.
`include "bulge_arc_tessellator_defines.svh"

module bulge_arc_tessellator #(
    parameter int STEPS_PER_HALF_TURN = bat_pkg::DEF_STEPS_PER_HALF_TURN,
    parameter int COORD_FRAC_BITS     = bat_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bat_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bat_pkg::t_out_word o_out_word
);

    logic          w_seg_valid, w_pop;
    bat_pkg::t_seg w_seg;

    bat_front u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_word,
        .i_pop(w_pop), .o_seg_valid(w_seg_valid), .o_seg(w_seg)
    );

    bat_back #(
        .STEPS_PER_HALF_TURN(STEPS_PER_HALF_TURN),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_seg_valid(w_seg_valid), .i_seg(w_seg), .o_pop(w_pop),
        .o_out_valid, .i_out_ready, .o_out_word
    );

    // queue and sequencer agree on occupancy
    `BAT_ASSERT_NOW(a_pop_needs_seg, w_pop, w_seg_valid, "pop from empty segment queue")
    `BAT_ASSERT_NOW(a_full_not_empty, !o_in_ready, w_seg_valid, "queue full but shows no segment")
    `BAT_ASSERT_NEXT(a_accept_queued, i_in_valid && o_in_ready, w_seg_valid, "accepted word not queued")

endmodule

// ----- dv/bulge_arc_tessellator_checker.sv -----
// Checker for the bulge arc tessellator: predicts the points of every segment
// word taken in and compares each point word given out. Depends on bat_pkg.
`timescale 1ns / 100ps

module bulge_arc_tessellator_checker #(
    parameter int STEPS = 18,
    parameter int FRAC  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bat_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bat_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_points_owed
);

    localparam longint GAIN_INV = 652032874;
    localparam longint QTR      = 64'sd1073741824;
    localparam longint HALF     = 64'sd2147483648;

    bat_pkg::t_out_word point_fifo[$];
    int fails = 0;
    int owed  = 0;

    longint atan_angles[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680350, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // append one expected point
    function automatic void enqueue_point(bat_pkg::t_out_word p);
        point_fifo = {point_fifo, p};
    endfunction

    // (a*b) >> sh on magnitudes, truncated toward zero, clamped to 63 bits
    function automatic longint scaled_product(longint a, longint b, int sh);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p  = 128'(ua) * 128'(ub);
        p  = p >> sh;
        r  = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // rotate (x, y) by a binary angle; shifts floor toward minus infinity
    function automatic void rotate_vec(inout longint x, inout longint y, input longint ang);
        logic [31:0] wrapped;
        longint a;
        longint tx;
        longint ty;
        wrapped = ang[31:0];
        a = longint'(signed'(wrapped));
        if (a > QTR) begin
            x = -x; y = -y; a = a - HALF;
        end else if (a < -QTR) begin
            x = -x; y = -y; a = a + HALF;
        end
        for (int i = 0; i < 24; i++) begin
            tx = y >>> i;
            ty = x >>> i;
            if (a >= 0) begin
                x = x - tx; y = y + ty; a = a - atan_angles[i];
            end else begin
                x = x + tx; y = y - ty; a = a + atan_angles[i];
            end
        end
    endfunction

    function automatic longint bulge_angle(longint b);
        longint x;
        longint y;
        longint z;
        longint tx;
        longint ty;
        x = longint'(1) <<< (FRAC + 24);
        y = b * (longint'(1) <<< 24);
        z = 0;
        for (int i = 0; i < 24; i++) begin
            tx = y >>> i;
            ty = x >>> i;
            if (y >= 0) begin
                x = x + tx; y = y - ty; z = z + atan_angles[i];
            end else begin
                x = x - tx; y = y + ty; z = z - atan_angles[i];
            end
        end
        if (z > QTR - 1) z = QTR - 1;
        if (z < -(QTR - 1)) z = -(QTR - 1);
        return z;
    endfunction

    function automatic bat_pkg::t_out_word make_point(longint x, longint y);
        bat_pkg::t_out_word p;
        p.point_x = (x > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                    (x < -64'sd2147483648) ? 32'sh8000_0000 : x[31:0];
        p.point_y = (y > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                    (y < -64'sd2147483648) ? 32'sh8000_0000 : y[31:0];
        p.last_point = 1'b0;
        return p;
    endfunction

    // queue every point that one segment word causes
    function automatic void tessellate_segment(bat_pkg::t_in_word w);
        longint sx, sy, ex, ey, b, dx, dy, z, half_sweep, q, x0, y0, h, cx, cy, rx, ry, m;
        logic [63:0] absw, nsteps, absb, t1, t2;
        sx = w.start_x; sy = w.start_y; ex = w.end_x; ey = w.end_y; b = w.bulge;
        dx = ex - sx;
        dy = ey - sy;
        enqueue_point(make_point(sx, sy));
        if (b != 0 && (dx != 0 || dy != 0)) begin
            z = bulge_angle(b);
            half_sweep = 2 * z;
            absw = (z < 0) ? 64'(-4 * z) : 64'(4 * z);
            nsteps = (absw * STEPS + 64'd2147483647) >> 31;
            if (nsteps == 0) nsteps = 1;
            absb = (b < 0) ? 64'(-b) : 64'(b);
            t1 = (64'd1 << (FRAC + 32)) / absb;
            t2 = absb << (32 - FRAC);
            q = longint'((t1 + t2) >> 1);
            x0 = (dx * GAIN_INV) >>> 6;
            y0 = (dy * GAIN_INV) >>> 6;
            for (longint k = 1; k < longint'(nsteps); k++) begin
                h = longint'((absw * 64'(k)) / (2 * nsteps));
                cx = GAIN_INV; cy = 0;
                rotate_vec(cx, cy, h);
                m = scaled_product(cy, q, 30);
                rx = x0; ry = y0;
                rotate_vec(rx, ry, ((b > 0) ? h : -h) - half_sweep);
                enqueue_point(make_point(sx + scaled_product(rx, m, 56),
                                         sy + scaled_product(ry, m, 56)));
            end
        end
        if (w.emit_end) enqueue_point(make_point(ex, ey));
        point_fifo[point_fifo.size() - 1].last_point = 1'b1;
    endfunction

    assign o_fail_count  = fails;
    assign o_points_owed = owed;

    // watch both channels at each edge
    always @(posedge i_clk) begin
        bat_pkg::t_out_word want;
        if (i_rst_n && i_in_valid && i_in_ready) tessellate_segment(i_in_word);
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (point_fifo.size() == 0) begin
                $error("point word with none expected: x=%0d y=%0d last=%0b",
                       i_out_word.point_x, i_out_word.point_y, i_out_word.last_point);
                fails <= fails + 1;
            end else begin
                want = point_fifo.pop_front();
                if (want.point_x !== i_out_word.point_x ||
                    want.point_y !== i_out_word.point_y ||
                    want.last_point !== i_out_word.last_point) begin
                    if (want.point_x !== i_out_word.point_x)
                        $error("point_x expected %0d got %0d", want.point_x, i_out_word.point_x);
                    if (want.point_y !== i_out_word.point_y)
                        $error("point_y expected %0d got %0d", want.point_y, i_out_word.point_y);
                    if (want.last_point !== i_out_word.last_point)
                        $error("last_point expected %0b got %0b",
                               want.last_point, i_out_word.last_point);
                    fails <= fails + 1;
                end
            end
        end
        owed = point_fifo.size();
    end

endmodule

// ----- dv/bulge_arc_tessellator_tb.sv -----
// Testbench top for the bulge arc tessellator: clock, reset, segment stimulus,
// point receiver and verdict. Depends on bat_pkg and the checker module.
`timescale 1ns / 100ps

module bulge_arc_tessellator_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    bat_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bat_pkg::t_out_word out_word;
    int                 fail_count;
    int                 points_owed;
    bit                 calm = 1'b0;
    bit                 hold_request = 1'b0;
    bit                 hold_done = 1'b0;
    int                 quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    bulge_arc_tessellator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_word(out_word)
    );

    bulge_arc_tessellator_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_word(out_word),
        .o_fail_count(fail_count), .o_points_owed(points_owed)
    );

    // offer one segment word and hold it until taken, then maybe idle
    task automatic send_segment(bat_pkg::t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic bat_pkg::t_in_word seg(int sx, int sy, int ex, int ey, int b, bit e);
        bat_pkg::t_in_word w;
        w.start_x = sx; w.start_y = sy; w.end_x = ex; w.end_y = ey;
        w.bulge = b; w.emit_end = e;
        return w;
    endfunction

    function automatic bat_pkg::t_in_word random_segment();
        bat_pkg::t_in_word w;
        int kind;
        kind = $urandom_range(0, 9);
        w.emit_end = 1'($urandom_range(0, 1));
        if (kind < 2) begin
            // full-range noise
            w.start_x = $urandom; w.start_y = $urandom;
            w.end_x = $urandom; w.end_y = $urandom; w.bulge = $urandom;
        end else begin
            w.start_x = $signed($urandom_range(0, 2000000)) - 1000000;
            w.start_y = $signed($urandom_range(0, 2000000)) - 1000000;
            w.end_x   = w.start_x + $signed($urandom_range(0, 4000000)) - 2000000;
            w.end_y   = w.start_y + $signed($urandom_range(0, 4000000)) - 2000000;
            w.bulge   = $signed($urandom_range(0, 262144)) - 131072;
            if (kind == 2) w.bulge = 0;
            if (kind == 3) begin
                w.end_x = w.start_x; w.end_y = w.start_y;
            end
        end
        return w;
    endfunction

    // receiver with random stalls and one long hold
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
                out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bulge_arc_tessellator_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: straight, zero chord, bulge extremes, saturation
        send_segment(seg(0, 0, 65536, 0, 0, 0));
        send_segment(seg(100, -100, 200000, 5, 0, 1));
        send_segment(seg(4000, 4000, 4000, 4000, 65536, 1));
        send_segment(seg(0, 0, 655360, 0, 65536, 1));
        send_segment(seg(0, 0, 655360, 0, -65536, 0));
        send_segment(seg(0, 0, 655360, 655360, 1, 1));
        send_segment(seg(0, 0, 655360, 655360, -1, 1));
        send_segment(seg(-5, 7, 300000, -90000, 32'sh7FFF_FFFF, 1));
        send_segment(seg(-5, 7, 300000, -90000, 32'sh8000_0000, 0));
        send_segment(seg(32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh0002_0000, 1));
        send_segment(seg(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                         -32'sh0003_0000, 1));
        send_segment(seg(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 0));
        send_segment(seg(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh0000_8000, 1));
        send_segment(seg(-1, -1, 0, 0, 32'sh0001_0000, 1));

        for (int i = 0; i < 250; i++) begin
            if (i == 60) hold_request = 1'b1;
            if (i == 120) begin
                // let the checker see the last accepted word before draining
                in_valid <= 1'b0;
                @(posedge i_clk);
                wait (points_owed == 0);
                @(posedge i_clk);
            end
            if (i == 220) calm = 1'b1;
            send_segment(random_segment());
        end
        in_valid <= 1'b0;
        @(posedge i_clk);

        wait (points_owed == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && points_owed == 0) begin
            $display("bulge_arc_tessellator_tb OK");
        end else begin
            $display("bulge_arc_tessellator_tb NOT OK");
        end
        $finish;
    end

endmodule
